[hdl/ssc_pkg.sv]
// shared types, constants and helpers of the span score closure block
package ssc_pkg;

  localparam int MAX_LEN   = 32;
  localparam int NUM_STEPS = 4;
  localparam int POS_W     = $clog2(MAX_LEN);
  localparam int STEP_W    = 2;
  localparam int LEN_W     = 6;
  localparam int NSTEP_W   = 3;
  localparam int SCORE_W   = 32;
  localparam int ADDR_W    = STEP_W + 2 * POS_W;
  localparam int DEPTH     = 1 << ADDR_W;

  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t NEG_INF   = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam score_t SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam score_t SCORE_MIN = {1'b1, {(SCORE_W-2){1'b0}}, 1'b1};

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_CLOSE = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic {
    REG_SENT_LEN  = 1'b0,
    REG_NUM_STEPS = 1'b1
  } cfg_reg_t;

  // one write and two reads per cycle toward the span table
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    score_t            wdata;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] rb;
  } ram_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [STEP_W-1:0] st,
                                                  input logic [POS_W-1:0] s,
                                                  input logic [POS_W-1:0] e);
    return {st, s, e};
  endfunction

endpackage

[hdl/ssc_ram.sv]
// span score table: one write port, two registered read ports
module ssc_ram
  import ssc_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output score_t   rd_a,
  output score_t   rd_b
);

  score_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.ra];
    rd_b <= mem[req.rb];
  end

endmodule

[hdl/ssc_alu.sv]
// shared saturating score adder with compare against the running best
module ssc_alu
  import ssc_pkg::*;
(
  input  score_t a,
  input  score_t b,
  input  score_t cmp,
  output score_t sum,
  output logic   gt
);

  logic signed [SCORE_W:0] wide;

  always_comb begin
    wide = $signed({a[SCORE_W-1], a}) + $signed({b[SCORE_W-1], b});
    if (a == NEG_INF || b == NEG_INF) begin
      sum = NEG_INF;
    end else if (wide[SCORE_W] != wide[SCORE_W-1]) begin
      sum = wide[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end else if (wide[SCORE_W-1:0] == NEG_INF) begin
      // minus infinity is reserved, clamp one above it
      sum = SCORE_MIN;
    end else begin
      sum = wide[SCORE_W-1:0];
    end
    gt = sum > cmp;
  end

endmodule

[hdl/ssc_seq.sv]
// sequencer: clearing pass, loads, closure walk, coverage query and result
module ssc_seq
  import ssc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [STEP_W-1:0]  in_step_index,
  input  logic [POS_W-1:0]   in_span_start,
  input  logic [POS_W-1:0]   in_span_end,
  input  score_t             in_span_value,
  input  logic [31:0]        in_coverage,
  input  logic               in_last_step,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [LEN_W-1:0]   cfg_wdata,
  output ram_req_t           ram_req,
  input  score_t             rd_a,
  input  score_t             rd_b,
  output score_t             alu_a,
  output score_t             alu_b,
  output score_t             alu_cmp,
  input  score_t             alu_sum,
  input  logic               alu_gt,
  output logic               out_valid,
  output score_t             out_future_score,
  output logic               out_closure_done
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE,
    C_SPAN, C_PAIR, C_DRAIN, C_WRITE, C_ACK,
    Q_WALK, Q_DRAIN, Q_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [NSTEP_W-1:0] steps_r, steps_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [POS_W-1:0]  d_r, d_nxt;
  logic [POS_W-1:0]  s_r, s_nxt;
  logic [POS_W-1:0]  j_r, j_nxt;
  logic [POS_W-1:0]  p_r, p_nxt;
  logic [POS_W-1:0]  run_start_r, run_start_nxt;
  logic              open_r, open_nxt;
  logic [31:0]       cov_r, cov_nxt;
  logic              last_r, last_nxt;
  logic              head_vld_r, head_vld_nxt;
  logic              pair_vld_r, pair_vld_nxt;
  logic              add_vld_r, add_vld_nxt;
  score_t            best_r, best_nxt;
  score_t            acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  score_t            out_score_r, out_score_nxt;
  logic              out_done_r, out_done_nxt;

  logic [LEN_W-1:0]   len_use;
  logic [NSTEP_W-1:0] steps_use;
  logic               accept;
  logic               in_active;
  logic [POS_W-1:0]   e_pos;
  logic               unc;
  logic               last_pos;

  assign len_use   = (len_r > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_r;
  assign steps_use = (steps_r > NSTEP_W'(NUM_STEPS)) ? NSTEP_W'(NUM_STEPS) : steps_r;
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign in_active = {1'b0, in_step_index} < steps_use;
  assign e_pos     = s_r + d_r;
  assign unc       = !cov_r[p_r];
  assign last_pos  = ({1'b0, p_r} == len_use - LEN_W'(1));

  // shared adder: query accumulates, closure joins two subspans
  assign alu_a   = add_vld_r ? acc_r : rd_a;
  assign alu_b   = add_vld_r ? rd_a : rd_b;
  assign alu_cmp = best_r;

  assign out_valid        = out_valid_r;
  assign out_future_score = out_score_r;
  assign out_closure_done = out_done_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    len_nxt       = len_r;
    steps_nxt     = steps_r;
    step_nxt      = step_r;
    d_nxt         = d_r;
    s_nxt         = s_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    run_start_nxt = run_start_r;
    open_nxt      = open_r;
    cov_nxt       = cov_r;
    last_nxt      = last_r;
    head_vld_nxt  = 1'b0;
    pair_vld_nxt  = 1'b0;
    add_vld_nxt   = 1'b0;
    best_nxt      = best_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_score_nxt = out_score_r;
    out_done_nxt  = out_done_r;
    ram_req       = '0;

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SENT_LEN:  len_nxt   = cfg_wdata;
        REG_NUM_STEPS: steps_nxt = cfg_wdata[NSTEP_W-1:0];
        default: ;
      endcase
    end

    // data returned by the table in the cycle after the read
    if (head_vld_r) begin
      best_nxt = rd_a;
    end else if (pair_vld_r && alu_gt) begin
      best_nxt = alu_sum;
    end
    if (add_vld_r) begin
      acc_nxt = alu_sum;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt_r;
        ram_req.wdata = NEG_INF;
        clr_cnt_nxt   = clr_cnt_r + ADDR_W'(1);
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          step_nxt = in_step_index;
          unique case (mode_t'(in_mode))
            MODE_LOAD: begin
              if (in_active && in_span_start <= in_span_end &&
                  {1'b0, in_span_end} < len_use) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cell_addr(in_step_index, in_span_start, in_span_end);
                ram_req.wdata = in_span_value;
              end
            end
            MODE_CLOSE: begin
              d_nxt = POS_W'(1);
              s_nxt = '0;
              if (in_active && len_use >= LEN_W'(2)) begin
                state_nxt = C_SPAN;
              end else begin
                state_nxt = C_ACK;
              end
            end
            MODE_QUERY: begin
              p_nxt    = '0;
              open_nxt = 1'b0;
              cov_nxt  = in_coverage;
              last_nxt = in_last_step;
              if (in_active && len_use != '0) begin
                state_nxt = Q_WALK;
              end else begin
                state_nxt = Q_FIN;
              end
            end
            default: ;
          endcase
        end
      end
      C_SPAN: begin
        ram_req.ra   = cell_addr(step_r, s_r, e_pos);
        head_vld_nxt = 1'b1;
        j_nxt        = s_r;
        state_nxt    = C_PAIR;
      end
      C_PAIR: begin
        ram_req.ra   = cell_addr(step_r, s_r, j_r);
        ram_req.rb   = cell_addr(step_r, j_r + POS_W'(1), e_pos);
        pair_vld_nxt = 1'b1;
        if (j_r == e_pos - POS_W'(1)) begin
          state_nxt = C_DRAIN;
        end else begin
          j_nxt = j_r + POS_W'(1);
        end
      end
      C_DRAIN: begin
        state_nxt = C_WRITE;
      end
      C_WRITE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cell_addr(step_r, s_r, e_pos);
        ram_req.wdata = best_r;
        // next span of this length, else first span of the next length
        if ({2'b0, s_r} + {2'b0, d_r} + 7'd1 < {1'b0, len_use}) begin
          s_nxt     = s_r + POS_W'(1);
          state_nxt = C_SPAN;
        end else if ({1'b0, d_r} + LEN_W'(1) < len_use) begin
          d_nxt     = d_r + POS_W'(1);
          s_nxt     = '0;
          state_nxt = C_SPAN;
        end else begin
          state_nxt = C_ACK;
        end
      end
      C_ACK: begin
        out_valid_nxt = 1'b1;
        out_score_nxt = '0;
        out_done_nxt  = 1'b1;
        state_nxt     = S_IDLE;
      end
      Q_WALK: begin
        if (unc && !open_r) begin
          run_start_nxt = p_r;
          open_nxt      = 1'b1;
        end
        if (!unc && open_r) begin
          // run closed by a covered position
          ram_req.ra  = cell_addr(step_r, run_start_r, p_r - POS_W'(1));
          add_vld_nxt = 1'b1;
          open_nxt    = 1'b0;
        end
        if (last_pos) begin
          if (unc) begin
            ram_req.ra  = cell_addr(step_r, open_r ? run_start_r : p_r, p_r);
            add_vld_nxt = 1'b1;
          end
          state_nxt = Q_DRAIN;
        end else begin
          p_nxt = p_r + POS_W'(1);
        end
      end
      Q_DRAIN: begin
        state_nxt = Q_FIN;
      end
      Q_FIN: begin
        if (last_r) begin
          out_valid_nxt = 1'b1;
          out_score_nxt = acc_r;
          out_done_nxt  = 1'b0;
          acc_nxt       = '0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      len_r       <= LEN_W'(32);
      steps_r     <= NSTEP_W'(1);
      open_r      <= 1'b0;
      last_r      <= 1'b0;
      head_vld_r  <= 1'b0;
      pair_vld_r  <= 1'b0;
      add_vld_r   <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      out_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      len_r       <= len_nxt;
      steps_r     <= steps_nxt;
      open_r      <= open_nxt;
      last_r      <= last_nxt;
      head_vld_r  <= head_vld_nxt;
      pair_vld_r  <= pair_vld_nxt;
      add_vld_r   <= add_vld_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      out_done_r  <= out_done_nxt;
    end
    step_r      <= step_nxt;
    d_r         <= d_nxt;
    s_r         <= s_nxt;
    j_r         <= j_nxt;
    p_r         <= p_nxt;
    run_start_r <= run_start_nxt;
    cov_r       <= cov_nxt;
    best_r      <= best_nxt;
    out_score_r <= out_score_nxt;
  end

endmodule

[hdl/span_score_closure_and_gap_sum.sv]
// a query or closure result appears in the same cycle that busy drops; a load never raises busy
// close: the single adder and the two-read table port walk each split point of every span,
//   shorter spans first
// one request at a time while busy is high; results are a one-cycle strobe
// reset: synchronous, a clearing pass sets all 4096 table entries to minus infinity
//   with busy high; configuration writes are taken during it
module span_score_closure_and_gap_sum
  import ssc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [STEP_W-1:0]  in_step_index,
  input  logic [POS_W-1:0]   in_span_start,
  input  logic [POS_W-1:0]   in_span_end,
  input  logic signed [SCORE_W-1:0] in_span_value,
  input  logic [31:0]        in_coverage,
  input  logic               in_last_step,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [LEN_W-1:0]   cfg_wdata,
  output logic               out_valid,
  output logic signed [SCORE_W-1:0] out_future_score,
  output logic               out_closure_done
);

  ram_req_t ram_req;
  score_t   rd_a;
  score_t   rd_b;
  score_t   alu_a;
  score_t   alu_b;
  score_t   alu_cmp;
  score_t   alu_sum;
  logic     alu_gt;

  ssc_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_step_index    (in_step_index),
    .in_span_start    (in_span_start),
    .in_span_end      (in_span_end),
    .in_span_value    (in_span_value),
    .in_coverage      (in_coverage),
    .in_last_step     (in_last_step),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .ram_req          (ram_req),
    .rd_a             (rd_a),
    .rd_b             (rd_b),
    .alu_a            (alu_a),
    .alu_b            (alu_b),
    .alu_cmp          (alu_cmp),
    .alu_sum          (alu_sum),
    .alu_gt           (alu_gt),
    .out_valid        (out_valid),
    .out_future_score (out_future_score),
    .out_closure_done (out_closure_done)
  );

  ssc_ram u_ram (
    .clk  (clk),
    .req  (ram_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  ssc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .cmp (alu_cmp),
    .sum (alu_sum),
    .gt  (alu_gt)
  );

  // every request with a result holds busy before its strobe, so strobes never touch
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in back-to-back cycles");

  // a closure request always occupies the sequencer
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_CLOSE) |=> busy)
    else $error("closure request did not raise busy");

  // a closure acknowledge carries a zero score
  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_closure_done) |-> (out_future_score == '0))
    else $error("closure acknowledge with nonzero score");

  // a result always follows a cycle with busy high
  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding busy request");

endmodule

[sim/tb_top.sv]
// testbench for span_score_closure_and_gap_sum: directed request table, then random sentences
`timescale 1ns / 100ps

module tb_top;
  import ssc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 60000;
  localparam int SETTLE_CYCLES = MAX_LEN + 8;

  typedef struct packed {
    logic [1:0]        mode;
    logic [STEP_W-1:0] step_index;
    logic [POS_W-1:0]  span_start;
    logic [POS_W-1:0]  span_end;
    score_t            span_value;
    logic [31:0]       coverage;
    logic              last_step;
  } span_request_t;

  typedef struct packed {
    score_t future_score;
    logic   closure_done;
  } cost_report_t;

  typedef struct {
    span_request_t req;
    bit            pinned;
    cost_report_t  pin;
  } opening_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = '0;
  logic [STEP_W-1:0] in_step_index = '0;
  logic [POS_W-1:0] in_span_start = '0;
  logic [POS_W-1:0] in_span_end = '0;
  logic signed [SCORE_W-1:0] in_span_value = '0;
  logic [31:0] in_coverage = '0;
  logic in_last_step = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [SCORE_W-1:0] out_future_score;
  logic out_closure_done;

  // predictor state
  score_t span_cost [NUM_STEPS][MAX_LEN][MAX_LEN];
  score_t gap_total = '0;
  logic [LEN_W-1:0] sent_len_cfg = 6'd32;
  logic [NSTEP_W-1:0] steps_cfg = 3'd1;

  cost_report_t future_cost_reports[$];
  opening_row_t opening_rows[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  span_score_closure_and_gap_sum DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_step_index    (in_step_index),
    .in_span_start    (in_span_start),
    .in_span_end      (in_span_end),
    .in_span_value    (in_span_value),
    .in_coverage      (in_coverage),
    .in_last_step     (in_last_step),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_future_score (out_future_score),
    .out_closure_done (out_closure_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int active_len();
    return (sent_len_cfg > MAX_LEN) ? MAX_LEN : int'(sent_len_cfg);
  endfunction

  function automatic int active_steps();
    return (steps_cfg > NUM_STEPS) ? NUM_STEPS : int'(steps_cfg);
  endfunction

  // minus infinity absorbs, everything else clips to the finite range
  function automatic score_t sat_sum(input score_t a, input score_t b);
    longint total;
    if (a == NEG_INF || b == NEG_INF) return NEG_INF;
    total = longint'(a) + longint'(b);
    if (total > longint'(SCORE_MAX)) return SCORE_MAX;
    if (total < longint'(SCORE_MIN)) return SCORE_MIN;
    return total[SCORE_W-1:0];
  endfunction

  function automatic void estimate_future_cost(input span_request_t r, output bit emits,
                                               output cost_report_t rep);
    int len, d, s, e, j, p, run_from;
    bit active, in_run;
    score_t joined;
    logic [STEP_W-1:0] st;
    len = active_len();
    st = r.step_index;
    active = (st < active_steps());
    emits = 1'b0;
    rep = '0;
    run_from = 0;
    in_run = 1'b0;
    case (r.mode)
      MODE_LOAD: begin
        if (active && r.span_start <= r.span_end && r.span_end < len)
          span_cost[st][r.span_start][r.span_end] = r.span_value;
      end
      MODE_CLOSE: begin
        // shorter spans first so every split reads final subspans
        if (active) begin
          for (d = 1; d < len; d++) begin
            for (s = 0; s + d < len; s++) begin
              e = s + d;
              for (j = s; j < e; j++) begin
                joined = sat_sum(span_cost[st][s][j], span_cost[st][j+1][e]);
                if (joined > span_cost[st][s][e]) span_cost[st][s][e] = joined;
              end
            end
          end
        end
        emits = 1'b1;
        rep.closure_done = 1'b1;
      end
      MODE_QUERY: begin
        if (active) begin
          for (p = 0; p < len; p++) begin
            if (!r.coverage[p]) begin
              if (!in_run) begin
                run_from = p;
                in_run = 1'b1;
              end
            end else if (in_run) begin
              gap_total = sat_sum(gap_total, span_cost[st][run_from][p-1]);
              in_run = 1'b0;
            end
          end
          if (in_run) gap_total = sat_sum(gap_total, span_cost[st][run_from][len-1]);
        end
        if (r.last_step) begin
          emits = 1'b1;
          rep.future_score = gap_total;
          gap_total = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic score_t pick_score();
    case ($urandom_range(0, 9))
      0: return NEG_INF;
      1: return SCORE_MAX;
      2: return SCORE_MIN;
      3: return '0;
      4, 5, 6: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_coverage();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return ~(32'h1 << $urandom_range(0, 31));
      2: return $urandom & $urandom;
      3: return $urandom | $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic span_request_t random_request();
    span_request_t r;
    r.mode = 2'($urandom_range(0, 3));
    r.step_index = STEP_W'($urandom_range(0, 3));
    r.span_start = POS_W'($urandom_range(0, 31));
    r.span_end = POS_W'($urandom_range(0, 31));
    r.span_value = pick_score();
    r.coverage = pick_coverage();
    r.last_step = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] mode, input logic [STEP_W-1:0] st,
                                  input logic [POS_W-1:0] s, input logic [POS_W-1:0] e,
                                  input score_t v, input logic [31:0] cov, input logic last,
                                  input bit pinned, input score_t pin_score,
                                  input logic pin_done);
    opening_row_t row;
    row.req = '{mode, st, s, e, v, cov, last};
    row.pinned = pinned;
    row.pin = '{pin_score, pin_done};
    opening_rows.push_back(row);
  endfunction

  // hold the request until the block takes it, then predict and maybe idle
  task automatic issue(input span_request_t r, input bit pinned, input cost_report_t pin);
    bit emits;
    cost_report_t rep;
    start <= 1'b1;
    in_mode <= r.mode;
    in_step_index <= r.step_index;
    in_span_start <= r.span_start;
    in_span_end <= r.span_end;
    in_span_value <= r.span_value;
    in_coverage <= r.coverage;
    in_last_step <= r.last_step;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    estimate_future_cost(r, emits, rep);
    if (emits) future_cost_reports.push_back(pinned ? pin : rep);
    if (!calm && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (future_cost_reports.size() != 0 || busy) @(posedge clk);
    // loads and quiet queries leave no result behind to wait for
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic retune(input logic [LEN_W-1:0] len_raw, input logic [NSTEP_W-1:0] steps_raw);
    logic [LEN_W-NSTEP_W-1:0] filler;
    filler = (LEN_W-NSTEP_W)'($urandom_range(0, 7));
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_SENT_LEN;
    cfg_wdata <= len_raw;
    @(posedge clk);
    sent_len_cfg = len_raw;
    cfg_index <= REG_NUM_STEPS;
    cfg_wdata <= {filler, steps_raw};
    @(posedge clk);
    steps_cfg = steps_raw;
    cfg_we <= 1'b0;
  endtask

  // loads, mostly a closure, then a few queries ending on the last step
  task automatic sentence_episode(input int len, input int steps);
    span_request_t r;
    logic [STEP_W-1:0] st;
    int n_loads, n_queries, e, w, q;
    st = (steps > 0) ? STEP_W'($urandom_range(0, steps - 1)) : STEP_W'($urandom_range(0, 3));
    n_loads = $urandom_range(1, (len > 4) ? 8 : 3);
    repeat (n_loads) begin
      r = random_request();
      r.mode = MODE_LOAD;
      r.step_index = st;
      if (len > 0) begin
        e = $urandom_range(0, len - 1);
        w = $urandom_range(0, e);
        if ($urandom_range(0, 1)) w = w % 3;
        r.span_end = POS_W'(e);
        r.span_start = POS_W'(e - w);
      end
      issue(r, 1'b0, '0);
    end
    if ($urandom_range(0, 9) != 0) begin
      r = random_request();
      r.mode = MODE_CLOSE;
      r.step_index = st;
      issue(r, 1'b0, '0);
    end
    n_queries = $urandom_range(1, 3);
    for (q = 0; q < n_queries; q++) begin
      r = random_request();
      r.mode = MODE_QUERY;
      r.step_index = st;
      r.last_step = (q == n_queries - 1);
      issue(r, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    cost_report_t want;
    if (out_valid) begin
      if (future_cost_reports.size() == 0) begin
        mismatch_count++;
        $error("result with no request pending: future_score %0d closure_done %0b",
               out_future_score, out_closure_done);
      end else begin
        want = future_cost_reports.pop_front();
        if (out_future_score !== want.future_score) begin
          mismatch_count++;
          $error("future_score: expected %0d, got %0d", want.future_score, out_future_score);
        end
        if (out_closure_done !== want.closure_done) begin
          mismatch_count++;
          $error("closure_done: expected %0b, got %0b", want.closure_done, out_closure_done);
        end
      end
    end
    if ((start && !busy) || out_valid) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0] len_raw;
    logic [NSTEP_W-1:0] steps_raw;
    int quota;
    foreach (span_cost[a, b, c]) span_cost[a][b][c] = NEG_INF;

    // runs at the reset setting: 32 positions, one step
    add_row(MODE_QUERY, 2'd0, 5'd0, 5'd0, '0, 32'h0, 1'b1, 1, NEG_INF, 1'b0);
    add_row(MODE_QUERY, 2'd1, 5'd0, 5'd0, '0, 32'h0, 1'b1, 1, '0, 1'b0);
    add_row(MODE_LOAD, 2'd0, 5'd0, 5'd0, SCORE_MAX, 32'h0, 1'b0, 0, '0, 1'b0);
    add_row(MODE_LOAD, 2'd0, 5'd1, 5'd1, SCORE_MAX, 32'h0, 1'b0, 0, '0, 1'b0);
    add_row(MODE_LOAD, 2'd0, 5'd31, 5'd31, NEG_INF, 32'h0, 1'b0, 0, '0, 1'b0);
    add_row(MODE_LOAD, 2'd0, 5'd2, 5'd30, SCORE_MIN, 32'h0, 1'b0, 0, '0, 1'b0);
    add_row(MODE_LOAD, 2'd0, 5'd6, 5'd6, SCORE_MIN, 32'h0, 1'b0, 0, '0, 1'b0);
    add_row(MODE_LOAD, 2'd0, 5'd8, 5'd8, SCORE_MIN, 32'h0, 1'b0, 0, '0, 1'b0);
    // start past end, inactive step with stray flag, unused mode: all ignored
    add_row(MODE_LOAD, 2'd0, 5'd9, 5'd4, 32'h0001_0000, 32'h0, 1'b0, 0, '0, 1'b0);
    add_row(MODE_LOAD, 2'd1, 5'd0, 5'd0, '0, 32'h0, 1'b1, 0, '0, 1'b0);
    add_row(MODE_UNUSED, 2'd0, 5'd0, 5'd0, '0, 32'h0, 1'b1, 0, '0, 1'b0);
    add_row(MODE_QUERY, 2'd0, 5'd0, 5'd0, '0, 32'hFFFF_FFFE, 1'b0, 0, '0, 1'b0);
    add_row(MODE_QUERY, 2'd0, 5'd0, 5'd0, '0, 32'hFFFF_FFFD, 1'b1, 1, SCORE_MAX, 1'b0);
    add_row(MODE_QUERY, 2'd0, 5'd0, 5'd0, '0, 32'hFFFF_FEBF, 1'b1, 1, SCORE_MIN, 1'b0);
    add_row(MODE_QUERY, 2'd0, 5'd0, 5'd0, '0, 32'hFFFF_FFFF, 1'b1, 1, '0, 1'b0);
    add_row(MODE_QUERY, 2'd0, 5'd0, 5'd0, '0, 32'h7FFF_FFFF, 1'b1, 1, NEG_INF, 1'b0);
    add_row(MODE_CLOSE, 2'd0, 5'd0, 5'd0, '0, 32'h0, 1'b1, 1, '0, 1'b1);
    add_row(MODE_CLOSE, 2'd3, 5'd0, 5'd0, '0, 32'h0, 1'b0, 1, '0, 1'b1);
    add_row(MODE_QUERY, 2'd0, 5'd0, 5'd0, '0, 32'h0, 1'b1, 0, '0, 1'b0);
    add_row(MODE_QUERY, 2'd0, 5'd0, 5'd0, '0, 32'h8000_0003, 1'b0, 0, '0, 1'b0);
    add_row(MODE_LOAD, 2'd0, 5'd3, 5'd4, 32'hFFFF_0000, 32'h0, 1'b0, 0, '0, 1'b0);
    add_row(MODE_LOAD, 2'd0, 5'd10, 5'd31, 32'h0002_8000, 32'h0, 1'b0, 0, '0, 1'b0);
    add_row(MODE_CLOSE, 2'd0, 5'd0, 5'd0, '0, 32'h0, 1'b0, 1, '0, 1'b1);
    add_row(MODE_QUERY, 2'd0, 5'd0, 5'd0, '0, 32'h0000_0C00, 1'b1, 0, '0, 1'b0);
    add_row(MODE_QUERY, 2'd0, 5'd0, 5'd0, '0, 32'hAAAA_AAAA, 1'b1, 0, '0, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i]) issue(opening_rows[i].req, opening_rows[i].pinned,
                                    opening_rows[i].pin);

    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin len_raw = 6'd1;  steps_raw = 3'd4; end
        1: begin len_raw = 6'd0;  steps_raw = 3'd2; end
        2: begin len_raw = 6'd32; steps_raw = 3'd4; end
        3: begin len_raw = 6'd63; steps_raw = 3'd7; end
        4: begin len_raw = 6'd5;  steps_raw = 3'd0; end
        5: begin len_raw = 6'd2;  steps_raw = 3'd3; end
        default: begin
          len_raw = LEN_W'($urandom_range(2, 12));
          steps_raw = ($urandom_range(0, 3) == 0) ? NSTEP_W'($urandom_range(5, 7))
                                                  : NSTEP_W'($urandom_range(1, 4));
        end
      endcase
      retune(len_raw, steps_raw);
      calm = (ph == 6 || ph == 7);
      // full-length closures run long, so keep those phases short
      quota = items_sent + ((active_len() > 16) ? 40 : 120);
      while (items_sent < quota) begin
        if ($urandom_range(0, 99) < 20) issue(random_request(), 1'b0, '0);
        else sentence_episode(active_len(), active_steps());
      end
    end

    drain();
    if (mismatch_count == 0 && future_cost_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ssc_pkg.sv
hdl/ssc_ram.sv
hdl/ssc_alu.sv
hdl/ssc_seq.sv
hdl/span_score_closure_and_gap_sum.sv
sim/tb_top.sv
